// ----- rtl/netpbm_header_parser_defines.svh -----
// assertion macros shared by the netpbm header parser
`ifndef NETPBM_HEADER_PARSER_DEFINES_SVH
`define NETPBM_HEADER_PARSER_DEFINES_SVH

// antecedent holds at an edge, consequent holds at the same edge
`define NHP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds at an edge, consequent holds at the next edge
`define NHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/nhp_pkg.sv -----
`timescale 1ns / 1ps

package nhp_pkg;

  // field widths
  localparam int unsigned DIM_BITS  = 16;
  localparam int unsigned CNT_BITS  = 16;
  localparam int unsigned ROW_BITS  = 19;
  localparam int unsigned IMG_BITS  = 35;
  localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  // characters of interest
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // image type digits
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_PBM_A = 3'd1;
  localparam logic [2:0] KIND_PGM_A = 3'd2;
  localparam logic [2:0] KIND_PPM_A = 3'd3;
  localparam logic [2:0] KIND_PBM_B = 3'd4;
  localparam logic [2:0] KIND_PGM_B = 3'd5;
  localparam logic [2:0] KIND_PPM_B = 3'd6;

  localparam logic [DIM_BITS-1:0] RAW8_LIMIT = DIM_BITS'(256);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_PARSE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PAL_BW   = 2'd0,
    PAL_GREY = 2'd1,
    PAL_RGB  = 2'd2
  } palette_e;

  typedef enum logic [1:0] {
    FMT_TEXT  = 2'd0,
    FMT_RAW1  = 2'd1,
    FMT_RAW8  = 2'd2,
    FMT_RAW16 = 2'd3
  } format_e;

  typedef enum logic [2:0] {
    PH_P      = 3'd0,
    PH_DIGIT  = 3'd1,
    PH_WIDTH  = 3'd2,
    PH_HEIGHT = 3'd3,
    PH_MAX    = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    status_e             status;
    logic [2:0]          image_type;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic [DIM_BITS-1:0] max_sample;
    logic [1:0]          channels;
    palette_e            palette_kind;
    format_e             data_format;
    logic [ROW_BITS-1:0] row_bytes;
    logic [IMG_BITS-1:0] image_bytes;
    logic [CNT_BITS-1:0] header_length;
  } header_item_t;

  // parser result before layout: a full header or an error
  typedef struct packed {
    logic                hdr_ok;
    status_e             status;
    logic [2:0]          image_type;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic [DIM_BITS-1:0] max_sample;
    logic [CNT_BITS-1:0] header_length;
  } raw_result_t;

endpackage

// ----- rtl/nhp_parser.sv -----
`timescale 1ns / 1ps

module nhp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  nhp_pkg::byte_item_t in_item_i,
  output logic                raw_valid_o,
  input  logic                raw_ready_i,
  output nhp_pkg::raw_result_t raw_o
);
  import nhp_pkg::*;

  // input register
  logic       s0_valid_q, s0_valid_d;
  byte_item_t s0_item_q;

  // parser state
  phase_e              phase_q, phase_d;
  logic [2:0]          kind_q, kind_d;
  logic [DIM_BITS-1:0] acc_q, acc_d;
  logic                innum_q, innum_d;
  logic                incom_q, incom_d;
  logic [DIM_BITS-1:0] w_q, w_d;
  logic [DIM_BITS-1:0] h_q, h_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;

  // result register
  logic        s1_valid_q, s1_valid_d;
  raw_result_t s1_raw_q;

  // state seen by this byte, after a restart
  phase_e              cur_phase;
  logic [2:0]          cur_kind;
  logic [DIM_BITS-1:0] cur_acc;
  logic                cur_innum;
  logic                cur_incom;
  logic [DIM_BITS-1:0] cur_w;
  logic [DIM_BITS-1:0] cur_h;
  logic [CNT_BITS-1:0] cur_cnt;

  logic [7:0]          c;
  logic                last;
  logic                is_dig;
  logic                is_sp;
  logic                bw;
  logic                proceed;
  logic [DIM_BITS+3:0] acc_ext;
  logic [DIM_BITS+3:0] acc_next;
  logic                ovf;
  logic                err;
  status_e             err_st;
  logic [2:0]          err_type;
  logic                hdr;
  logic [DIM_BITS-1:0] hdr_w, hdr_h, hdr_mx;
  logic                res_valid;
  raw_result_t         res;

  logic s1_ready;
  logic s0_fire;
  logic in_fire;

  // handshake between stages
  assign s1_ready   = !s1_valid_q || raw_ready_i;
  assign s0_fire    = s0_valid_q && (!res_valid || s1_ready);
  assign in_ready_o = !s0_valid_q || s0_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // byte classification and decimal accumulate
  always_comb begin
    c        = s0_item_q.byte_value;
    last     = s0_item_q.last_byte;
    is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
    is_sp    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    acc_ext  = {4'b0000, cur_acc};
    acc_next = (acc_ext << 3) + (acc_ext << 1) + {{DIM_BITS{1'b0}}, c[3:0]};
    ovf      = (acc_next[DIM_BITS+3:DIM_BITS] != 4'b0000);
  end

  // restart on the first byte of a file
  always_comb begin
    if (s0_item_q.first_byte) begin
      cur_phase = PH_P;
      cur_kind  = KIND_NONE;
      cur_acc   = '0;
      cur_innum = 1'b0;
      cur_incom = 1'b0;
      cur_w     = '0;
      cur_h     = '0;
      cur_cnt   = '0;
    end else begin
      cur_phase = phase_q;
      cur_kind  = kind_q;
      cur_acc   = acc_q;
      cur_innum = innum_q;
      cur_incom = incom_q;
      cur_w     = w_q;
      cur_h     = h_q;
      cur_cnt   = cnt_q;
    end
  end

  // next state and result for one byte
  always_comb begin
    phase_d  = cur_phase;
    kind_d   = cur_kind;
    acc_d    = cur_acc;
    innum_d  = cur_innum;
    incom_d  = cur_incom;
    w_d      = cur_w;
    h_d      = cur_h;
    err      = 1'b0;
    err_st   = ST_PARSE;
    err_type = cur_kind;
    hdr      = 1'b0;
    hdr_w    = cur_w;
    hdr_h    = cur_h;
    hdr_mx   = cur_acc;
    proceed  = 1'b0;
    bw       = (cur_kind == KIND_PBM_A) || (cur_kind == KIND_PBM_B);

    // header length saturates
    if (cur_phase == PH_DONE || cur_cnt == CNT_MAX) begin
      cnt_d = cur_cnt;
    end else begin
      cnt_d = cur_cnt + CNT_BITS'(1);
    end

    unique case (cur_phase)
      PH_DONE: begin
      end
      PH_P: begin
        err_st   = ST_INVALID;
        err_type = KIND_NONE;
        if (c != CH_P) begin
          err = 1'b1;
        end else begin
          phase_d = PH_DIGIT;
          err     = last;
        end
      end
      PH_DIGIT: begin
        err_st   = ST_INVALID;
        err_type = KIND_NONE;
        if (c < CH_ONE || c > CH_SIX || last) begin
          err = 1'b1;
        end else begin
          kind_d  = c[2:0];
          phase_d = PH_WIDTH;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAX: begin
        proceed = 1'b1;
        // a number in progress: extend it or close it
        if (cur_innum) begin
          if (is_dig) begin
            proceed = 1'b0;
            if (ovf) begin
              err = 1'b1;
            end else begin
              acc_d = acc_next[DIM_BITS-1:0];
              err   = last;
            end
          end else begin
            innum_d = 1'b0;
            if (cur_phase == PH_MAX) begin
              hdr     = 1'b1;
              proceed = 1'b0;
            end else if (cur_phase == PH_HEIGHT && bw) begin
              hdr     = 1'b1;
              hdr_h   = cur_acc;
              hdr_mx  = DIM_BITS'(1);
              proceed = 1'b0;
            end else if (cur_phase == PH_WIDTH) begin
              w_d     = cur_acc;
              phase_d = PH_HEIGHT;
            end else begin
              h_d     = cur_acc;
              phase_d = PH_MAX;
            end
          end
        end
        // whitespace, comments and number starts
        if (proceed) begin
          if (cur_incom) begin
            if (c == CH_LF) begin
              incom_d = 1'b0;
            end
          end else if (c == CH_HASH) begin
            incom_d = 1'b1;
          end else if (is_dig) begin
            innum_d = 1'b1;
            acc_d   = DIM_BITS'(c[3:0]);
          end else if (!is_sp) begin
            err = 1'b1;
          end
          if (last) begin
            err = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    res_valid = err || hdr;
    if (res_valid) begin
      phase_d = PH_DONE;
    end

    res.hdr_ok        = hdr;
    res.status        = err ? err_st : ST_OK;
    res.image_type    = err ? err_type : cur_kind;
    res.width         = err ? '0 : hdr_w;
    res.height        = err ? '0 : hdr_h;
    res.max_sample    = err ? '0 : hdr_mx;
    res.header_length = cnt_d;
  end

  // input register
  always_comb begin
    if (in_fire) begin
      s0_valid_d = 1'b1;
    end else if (s0_fire) begin
      s0_valid_d = 1'b0;
    end else begin
      s0_valid_d = s0_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_item_q <= in_item_i;
    end
  end

  // parser state advances once per transfer out of the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_P;
      kind_q  <= KIND_NONE;
      acc_q   <= '0;
      innum_q <= 1'b0;
      incom_q <= 1'b0;
      w_q     <= '0;
      h_q     <= '0;
      cnt_q   <= '0;
    end else if (s0_fire) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      acc_q   <= acc_d;
      innum_q <= innum_d;
      incom_q <= incom_d;
      w_q     <= w_d;
      h_q     <= h_d;
      cnt_q   <= cnt_d;
    end
  end

  // result register
  always_comb begin
    if (s0_fire && res_valid) begin
      s1_valid_d = 1'b1;
    end else if (raw_ready_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_fire && res_valid) begin
      s1_raw_q <= res;
    end
  end

  assign raw_valid_o = s1_valid_q;
  assign raw_o       = s1_raw_q;

endmodule

// ----- rtl/nhp_layout.sv -----
`timescale 1ns / 1ps

module nhp_layout (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  raw_valid_i,
  output logic                  raw_ready_o,
  input  nhp_pkg::raw_result_t  raw_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output nhp_pkg::header_item_t out_item_o
);
  import nhp_pkg::*;

  logic         out_valid_q, out_valid_d;
  header_item_t out_item_q;
  header_item_t item;
  logic         load;

  logic [2:0]          t;
  logic                rgb;
  logic [ROW_BITS-1:0] w_ext;
  logic [ROW_BITS-1:0] w_ch;
  logic [ROW_BITS-1:0] row;
  logic [IMG_BITS-1:0] img;

  assign raw_ready_o = !out_valid_q || out_ready_i;
  assign load        = raw_valid_i && raw_ready_o;

  // channel count, palette, format and byte counts
  always_comb begin
    t     = raw_i.image_type;
    rgb   = (t == KIND_PPM_A) || (t == KIND_PPM_B);
    w_ext = ROW_BITS'(raw_i.width);
    w_ch  = rgb ? ((w_ext << 1) + w_ext) : w_ext;

    item               = '0;
    item.status        = raw_i.status;
    item.image_type    = raw_i.image_type;
    item.header_length = raw_i.header_length;
    item.data_format   = FMT_TEXT;
    row                = '0;

    if (raw_i.hdr_ok) begin
      item.status     = (raw_i.width == '0 || raw_i.height == '0) ? ST_INVALID : ST_OK;
      item.width      = raw_i.width;
      item.height     = raw_i.height;
      item.max_sample = raw_i.max_sample;
      item.channels   = rgb ? 2'd3 : 2'd1;
      if (t == KIND_PBM_A || t == KIND_PBM_B) begin
        item.palette_kind = PAL_BW;
      end else if (rgb) begin
        item.palette_kind = PAL_RGB;
      end else begin
        item.palette_kind = PAL_GREY;
      end
      if (t <= KIND_PPM_A) begin
        item.data_format = FMT_TEXT;
      end else if (t == KIND_PBM_B) begin
        item.data_format = FMT_RAW1;
        row              = (w_ext + ROW_BITS'(7)) >> 3;
      end else if (raw_i.max_sample < RAW8_LIMIT) begin
        item.data_format = FMT_RAW8;
        row              = w_ch;
      end else begin
        item.data_format = FMT_RAW16;
        row              = w_ch << 1;
      end
    end

    img              = IMG_BITS'(row) * IMG_BITS'(raw_i.height);
    item.row_bytes   = row;
    item.image_bytes = img;
  end

  // output register
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q <= item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- rtl/netpbm_header_parser.sv -----
// Netpbm (PBM/PGM/PPM) header parser. Feed the file one byte per transfer, with
// first_byte set on the byte that opens a file and last_byte on the final byte of
// the buffer. The block takes one byte every cycle while it is not stalled and
// holds a small parse state (phase, type digit, running number, comment flag,
// saved width and height, byte count). When the header ends, or an error stops
// it, one result is presented on the output once the byte that caused it has
// passed the input register, the parse result register and then the layout
// register. The layout stage derives channels, palette, data format, row bytes
// and image bytes, with its one multiplier (row bytes times height) in that stage.
// After a result further bytes are ignored until the next first_byte. Up to two
// results can wait, one in the layout register and one in the parse result
// register; the input keeps flowing meanwhile and stalls only when a third byte
// that ends a header finds both still held.
`timescale 1ns / 1ps

`include "netpbm_header_parser_defines.svh"

module netpbm_header_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  nhp_pkg::byte_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output nhp_pkg::header_item_t out_item_o
);
  import nhp_pkg::*;

  logic        raw_valid;
  logic        raw_ready;
  raw_result_t raw;

  // result side conditions used by the checks below
  logic out_ok;
  logic out_ok_shape;
  logic out_nokind;
  logic out_invalid;
  logic raw_stall;

  // byte parser
  nhp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .raw_valid_o (raw_valid),
    .raw_ready_i (raw_ready),
    .raw_o       (raw)
  );

  // derived layout fields and output register
  nhp_layout u_layout (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .raw_valid_i (raw_valid),
    .raw_ready_o (raw_ready),
    .raw_i       (raw),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  assign out_ok       = out_valid_o && (out_item_o.status == ST_OK);
  assign out_ok_shape = (out_item_o.width != '0) && (out_item_o.height != '0)
                        && (out_item_o.channels != 2'd0);
  assign out_nokind   = out_valid_o && (out_item_o.image_type == KIND_NONE);
  assign out_invalid  = (out_item_o.status == ST_INVALID);
  assign raw_stall    = raw_valid && !raw_ready;

  // an ok header always has a nonzero size and channel count
  `NHP_ASSERT_SAME(a_ok_size, clk_i, rst_ni, out_ok, out_ok_shape, "ok header with zero size")
  // a bad magic is reported as an invalid file
  `NHP_ASSERT_SAME(a_magic_status, clk_i, rst_ni, out_nokind, out_invalid, "bad magic status")
  // a parse result waiting on the layout stage is held
  `NHP_ASSERT_NEXT(a_raw_hold, clk_i, rst_ni, raw_stall, raw_valid && $stable(raw), "result not held")

endmodule
